// ----- rtl/sca_pkg.sv -----
// ----------------------------------------------------------------------------
// sca_pkg: shared types and constants for the scan code translator
// Event and result payload structs, key codes and the set 2 to ASCII table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sca_pkg;

    // Keyboard event as it arrives
    typedef struct packed {
        logic       is_make;
        logic [7:0] scan_code;
    } sca_in_t;

    // Translated result
    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic       new_press;
        logic       caps_on;
    } sca_out_t;

    localparam int unsigned HELD_WORDS = 6;

    localparam logic [7:0] CODE_LIMIT    = 8'h60;
    localparam logic [7:0] CAPS_CODE     = 8'h58;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_LOWER_Z = 7'h7A;
    localparam int unsigned CASE_BIT     = 5;
    localparam logic [6:0] NO_CHAR       = 7'h00;

    // Map a set 2 code below 0x60 to lower case ASCII; NO_CHAR when unmapped
    function automatic logic [6:0] key_map(input logic [6:0] code);
        logic [6:0] c;
        c = NO_CHAR;
        unique case (code)
            7'h0E: c = 7'h60; // `
            7'h15: c = 7'h71; // q
            7'h16: c = 7'h31; // 1
            7'h1A: c = 7'h7A; // z
            7'h1B: c = 7'h73; // s
            7'h1C: c = 7'h61; // a
            7'h1D: c = 7'h77; // w
            7'h1E: c = 7'h32; // 2
            7'h21: c = 7'h63; // c
            7'h22: c = 7'h78; // x
            7'h23: c = 7'h64; // d
            7'h24: c = 7'h65; // e
            7'h25: c = 7'h34; // 4
            7'h26: c = 7'h33; // 3
            7'h29: c = 7'h20; // space
            7'h2A: c = 7'h76; // v
            7'h2B: c = 7'h66; // f
            7'h2C: c = 7'h74; // t
            7'h2D: c = 7'h72; // r
            7'h2E: c = 7'h35; // 5
            7'h31: c = 7'h6E; // n
            7'h32: c = 7'h62; // b
            7'h33: c = 7'h68; // h
            7'h34: c = 7'h67; // g
            7'h35: c = 7'h79; // y
            7'h36: c = 7'h36; // 6
            7'h3A: c = 7'h6D; // m
            7'h3B: c = 7'h6A; // j
            7'h3C: c = 7'h75; // u
            7'h3D: c = 7'h37; // 7
            7'h3E: c = 7'h38; // 8
            7'h41: c = 7'h2C; // ,
            7'h42: c = 7'h6B; // k
            7'h43: c = 7'h69; // i
            7'h44: c = 7'h6F; // o
            7'h45: c = 7'h30; // 0
            7'h46: c = 7'h39; // 9
            7'h49: c = 7'h2E; // .
            7'h4A: c = 7'h2F; // /
            7'h4B: c = 7'h6C; // l
            7'h4C: c = 7'h3B; // ;
            7'h4D: c = 7'h70; // p
            7'h4E: c = 7'h2D; // -
            7'h52: c = 7'h27; // '
            7'h54: c = 7'h5B; // [
            7'h55: c = 7'h3D; // =
            7'h5A: c = 7'h0A; // line feed
            7'h5B: c = 7'h5D; // ]
            7'h5D: c = 7'h5C; // backslash
            default: c = NO_CHAR;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sca_in_stage.sv -----
// ----------------------------------------------------------------------------
// sca_in_stage: input register for keyboard events
// Captures one event per cycle while key_ready is high and holds it until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sca_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              key_valid,
    output logic                   key_ready,
    input  wire sca_pkg::sca_in_t  key_event,
    output logic                   item_valid,
    output sca_pkg::sca_in_t       item,
    input  wire logic              item_take
);
    import sca_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    sca_in_t item_reg;

    // Accept when empty or when the held event moves on this cycle
    assign key_ready  = !valid_reg || item_take;
    assign valid_next = key_valid || (valid_reg && !item_take);

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (key_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on each transfer
    always_ff @(posedge clk)
    begin
        if (key_valid && key_ready)
        begin
            item_reg <= key_event;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- rtl/sca_core.sv -----
// ----------------------------------------------------------------------------
// sca_core: held-key map, caps lock and ASCII translation
// Updates key state and loads the result register in the cycle an event
// leaves the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sca_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire sca_pkg::sca_in_t  item,
    output logic                   item_take,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output sca_pkg::sca_out_t      result
);
    import sca_pkg::*;

    logic [15:0] held_reg  [HELD_WORDS];
    logic [15:0] held_next [HELD_WORDS];
    logic        caps_reg;
    logic        caps_next;
    logic        res_valid_reg;
    sca_out_t    result_reg;
    sca_out_t    result_next;

    logic        fire;
    logic        code_ok;
    logic [2:0]  word_idx;
    logic [3:0]  bit_idx;
    logic        held_bit;
    logic [6:0]  mapped;

    // Result register frees up when empty or drained this cycle
    assign item_take = !res_valid_reg || res_ready;
    assign fire      = item_valid && item_take;

    assign code_ok  = item.scan_code < CODE_LIMIT;
    assign word_idx = item.scan_code[6:4];
    assign bit_idx  = item.scan_code[3:0];
    assign mapped   = key_map(item.scan_code[6:0]);

    // Translate the event and work out the next key state
    always_comb
    begin
        held_next   = held_reg;
        caps_next   = caps_reg;
        held_bit    = 1'b0;
        result_next = '0;
        if (code_ok)
        begin
            held_bit = held_reg[word_idx][bit_idx];
            if (!item.is_make)
            begin
                held_next[word_idx][bit_idx] = 1'b0;
            end
            else if (!held_bit)
            begin
                held_next[word_idx][bit_idx] = 1'b1;
                result_next.new_press        = 1'b1;
                if (item.scan_code == CAPS_CODE)
                begin
                    caps_next = !caps_reg;
                end
                else if (mapped != NO_CHAR)
                begin
                    result_next.char_valid = 1'b1;
                    result_next.char_code  = mapped;
                    // Upper case letters while caps lock is on
                    if (caps_reg && mapped >= ASCII_LOWER_A && mapped <= ASCII_LOWER_Z)
                    begin
                        result_next.char_code[CASE_BIT] = 1'b0;
                    end
                end
            end
        end
        result_next.caps_on = caps_next;
    end

    // Advance key state on each event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < HELD_WORDS; w++)
            begin
                held_reg[w] <= '0;
            end
            caps_reg <= 1'b0;
        end
        else if (fire)
        begin
            held_reg <= held_next;
            caps_reg <= caps_next;
        end
    end

    // Hold result valid until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            res_valid_reg <= item_valid;
        end
    end

    // Load result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

// ----- rtl/scan_code_to_ascii_translator.sv -----
// ----------------------------------------------------------------------------
// scan_code_to_ascii_translator: keyboard set 2 events to ASCII characters
// Tracks held keys and caps lock; emits one result for every event.
//
//   channel  | valid      | ready      | payload
//   ---------+------------+------------+-------------------------------------
//   key in   | key_valid  | key_ready  | key_event  (is_make, scan_code)
//   char out | res_valid  | res_ready  | result     (char_valid, char_code,
//            |            |            |             new_press, caps_on)
//
// One event per cycle sustained while res_ready stays high; each event passes
// through the input register, then the result register, before its result
// can transfer.
// Key map and caps lock update in the cycle an event enters the result
// register, so the next event always sees them.
// Reset clears the held-key map, caps lock and both valid flags at once.
// A stalled result register holds the event in the input register; both
// stages stay full before key_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scan_code_to_ascii_translator (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              key_valid,
    output logic                   key_ready,
    input  wire sca_pkg::sca_in_t  key_event,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output sca_pkg::sca_out_t      result
);
    import sca_pkg::*;

    logic    item_valid;
    logic    item_take;
    sca_in_t item;

    // Register incoming events
    sca_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_valid  (key_valid),
        .key_ready  (key_ready),
        .key_event  (key_event),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    // Translate and register the result
    sca_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .result     (result)
    );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for scan_code_to_ascii_translator
// Sends set 2 keyboard events over the valid/ready input channel, predicts
// each translated result from a local model of the held-key map and caps lock,
// and compares every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import sca_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     key_valid = 1'b0;
    logic     key_ready;
    sca_in_t  key_event = '0;
    logic     res_valid;
    logic     res_ready = 1'b0;
    sca_out_t result;

    // Local copy of the key state
    logic [15:0] held_map [0:5];
    logic        caps_state;

    sca_out_t expected_chars [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    scan_code_to_ascii_translator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_ready (key_ready),
        .key_event (key_event),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .result    (result)
    );

    always #5 clk = ~clk;

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0d] mismatch on %s: got %0h, expected %0h", cycle_count, what, got, want);
        error_count++;
    endtask

    // Lower case ASCII for a code below 0x60; '#' marks an unmapped code
    function automatic logic [6:0] ascii_of(input logic [7:0] code);
        string row;
        byte   c;
        case (code[7:4])
            4'h0:    row = "##############`#";
            4'h1:    row = "#####q1###zsaw2#";
            4'h2:    row = "#cxde43## vftr5#";
            4'h3:    row = "#nbhgy6###mju78#";
            4'h4:    row = "#,kio09##./l;p-#";
            default: row = "##'#[=####\n]#\\##";
        endcase
        c = row[code[3:0]];
        return (c == "#") ? NO_CHAR : c[6:0];
    endfunction

    // Update the key state for one event and queue the result it causes
    task automatic predict_translation(input sca_in_t ev);
        sca_out_t    r;
        logic [15:0] mask;
        logic [6:0]  ch;
        r = '0;
        if (ev.scan_code < CODE_LIMIT)
        begin
            mask = 16'h1 << ev.scan_code[3:0];
            if (!ev.is_make)
            begin
                held_map[ev.scan_code[7:4]] &= ~mask;
            end
            else if ((held_map[ev.scan_code[7:4]] & mask) == '0)
            begin
                r.new_press = 1'b1;
                if (ev.scan_code == CAPS_CODE)
                begin
                    caps_state = ~caps_state;
                end
                else
                begin
                    ch = ascii_of(ev.scan_code);
                    if (ch != NO_CHAR)
                    begin
                        if (caps_state && ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z)
                            ch[CASE_BIT] = 1'b0;
                        r.char_valid = 1'b1;
                        r.char_code  = ch;
                    end
                end
                held_map[ev.scan_code[7:4]] |= mask;
            end
        end
        r.caps_on = caps_state;
        expected_chars.push_back(r);
    endtask

    function automatic sca_in_t key_ev(input logic make, input logic [7:0] code);
        sca_in_t ev;
        ev.is_make   = make;
        ev.scan_code = code;
        return ev;
    endfunction

    // Drive one event and hold it until the transfer
    task automatic send_key(input sca_in_t ev);
        if ($urandom_range(99) < send_idle_pct)
        begin
            do
            begin
                key_valid <= 1'b0;
                @(posedge clk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        key_valid <= 1'b1;
        key_event <= ev;
        do @(posedge clk); while (!key_ready);
        predict_translation(ev);
    endtask

    // Hold off the sender until every predicted result has come back
    task automatic drain_results();
        key_valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // Randomly stall the result channel and check each result transfer
    always @(posedge clk)
    begin
        sca_out_t want;
        if (res_valid && res_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                report_mismatch("unexpected result", int'(result), 0);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (result.char_valid != want.char_valid)
                    report_mismatch("char_valid", int'(result.char_valid),
                                    int'(want.char_valid));
                if (result.char_code != want.char_code)
                    report_mismatch("char_code", int'(result.char_code),
                                    int'(want.char_code));
                if (result.new_press != want.new_press)
                    report_mismatch("new_press", int'(result.new_press),
                                    int'(want.new_press));
                if (result.caps_on != want.caps_on)
                    report_mismatch("caps_on", int'(result.caps_on), int'(want.caps_on));
            end
        end
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Mostly mapped keys, often caps lock, sometimes any code below the limit
    function automatic logic [7:0] pick_scan_code();
        logic [7:0] code;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return CAPS_CODE;
        code = 8'($urandom_range(8'h5F));
        if (pick < 75)
        begin
            while (ascii_of(code) == NO_CHAR)
                code = 8'($urandom_range(8'h5F));
        end
        return code;
    endfunction

    task automatic test_press_release();
        send_key(key_ev(1'b1, 8'h00));   // unmapped lowest code
        send_key(key_ev(1'b0, 8'h00));
        send_key(key_ev(1'b1, 8'h1C));   // a
        send_key(key_ev(1'b1, 8'h1C));   // typematic repeat gives nothing
        send_key(key_ev(1'b0, 8'h1C));
        send_key(key_ev(1'b1, 8'h0E));   // lowest mapped code
        send_key(key_ev(1'b1, 8'h5D));   // backslash
        send_key(key_ev(1'b1, 8'h5A));   // line feed
        send_key(key_ev(1'b1, 8'h29));   // space
        send_key(key_ev(1'b0, 8'h33));   // release of a key never pressed
        send_key(key_ev(1'b1, 8'h5F));   // highest code below the limit
    endtask

    task automatic test_caps_lock();
        send_key(key_ev(1'b1, CAPS_CODE));
        send_key(key_ev(1'b1, CAPS_CODE));   // held caps key must not toggle again
        send_key(key_ev(1'b1, 8'h1A));       // Z
        send_key(key_ev(1'b1, 8'h16));       // digits ignore caps
        send_key(key_ev(1'b1, 8'h1C));       // A
        drain_results();
        send_key(key_ev(1'b0, CAPS_CODE));
        send_key(key_ev(1'b1, CAPS_CODE));   // caps off
        send_key(key_ev(1'b0, 8'h1A));
        send_key(key_ev(1'b1, 8'h1A));       // z
    endtask

    task automatic test_ignored_codes();
        send_key(key_ev(1'b1, CODE_LIMIT));
        send_key(key_ev(1'b0, CODE_LIMIT));
        send_key(key_ev(1'b1, 8'hFF));
        send_key(key_ev(1'b0, 8'hFF));
        send_key(key_ev(1'b1, 8'hF0));
        send_key(key_ev(1'b0, 8'hE0));
        send_key(key_ev(1'b1, 8'h80));
    endtask

    // Realistic typing: press free keys, release held ones, with some noise
    task automatic test_random_typing(input int key_count, input int s_pct, input int r_pct);
        int         sent;
        logic [7:0] code;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < key_count)
        begin
            if ($urandom_range(99) < 8)
            begin
                code = 8'($urandom_range(8'hFF, 8'h60));
                send_key(key_ev(1'($urandom_range(1)), code));
            end
            else
            begin
                code = pick_scan_code();
                if (held_map[code[7:4]][code[3:0]])
                    send_key(key_ev($urandom_range(99) < 20, code));
                else
                    send_key(key_ev($urandom_range(99) >= 5, code));
                sent++;
            end
        end
        drain_results();
    endtask

    initial
    begin
        foreach (held_map[i])
            held_map[i] = '0;
        caps_state = 1'b0;

        // Hold reset low, then release it
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 34;
        recv_idle_pct = 87;
        test_press_release();
        test_caps_lock();
        test_ignored_codes();
        drain_results();

        test_random_typing(200, 34, 87);
        test_random_typing(200, 87, 34);
        test_random_typing(200, 0, 0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
